### src/velocity_ramp_with_stop_profile_unit_assert.svh
// assertion macros for the velocity ramp unit
// expects clk and rst_n in the scope of the module that uses them
`ifndef VELOCITY_RAMP_WITH_STOP_PROFILE_UNIT_ASSERT_SVH
`define VELOCITY_RAMP_WITH_STOP_PROFILE_UNIT_ASSERT_SVH

// same-cycle implication
`define VRSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vrsp_pkg.sv
// shared types, widths, step codes and microcode rom for the velocity ramp unit
// no dependencies
package vrsp_pkg;

  localparam int SPEED_W  = 16;
  localparam int ACCEL_W  = 16;
  localparam int DIST_W   = 25;
  localparam int PROD_W   = 42;   // 2*accel*|d| fits in 41 bits, kept even for the root
  localparam int ROOT_W   = PROD_W / 2;
  localparam int CNT_W    = $clog2(ROOT_W);
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PER_TICK = 1'd1;

  // program steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SQINIT = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SQ     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_CLAMP  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RAMP   = 3'd5;

  // sequencing conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
  localparam logic [COND_W-1:0] COND_GOTO     = 3'd1;
  localparam logic [COND_W-1:0] COND_IN_WAIT  = 3'd2;
  localparam logic [COND_W-1:0] COND_LOOP     = 3'd3;
  localparam logic [COND_W-1:0] COND_OUT_WAIT = 3'd4;

  typedef struct packed {
    logic latch_in;
    logic mul_en;
    logic sq_init;
    logic sq_step;
    logic clamp_en;
    logic ramp_en;
  } ctrl_t;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
    ctrl_t             op;
  } cw_t;

  function automatic cw_t rom(input logic [STEP_W-1:0] step);
    cw_t cw;
    cw = '0;
    case (step)
      STEP_IDLE: begin
        cw.cond = COND_IN_WAIT;
        cw.target = STEP_RAMP;      // plain tick skips the root
        cw.op.latch_in = 1'b1;
      end
      STEP_MUL: begin
        cw.cond = COND_NEXT;
        cw.op.mul_en = 1'b1;
      end
      STEP_SQINIT: begin
        cw.cond = COND_NEXT;
        cw.op.sq_init = 1'b1;
      end
      STEP_SQ: begin
        cw.cond = COND_LOOP;
        cw.target = STEP_SQ;
        cw.op.sq_step = 1'b1;
      end
      STEP_CLAMP: begin
        cw.cond = COND_NEXT;
        cw.op.clamp_en = 1'b1;
      end
      STEP_RAMP: begin
        cw.cond = COND_OUT_WAIT;
        cw.target = STEP_IDLE;
        cw.op.ramp_en = 1'b1;
      end
      default: begin
        cw.cond = COND_GOTO;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

### src/vrsp_seq.sv
// microcode sequencer: step counter, loop counter and control rom lookup
// depends on vrsp_pkg and the assertion macro header
`include "velocity_ramp_with_stop_profile_unit_assert.svh"

module vrsp_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_command,
  input  logic           out_busy,
  output logic           in_ready,
  output vrsp_pkg::ctrl_t ctrl
);

  logic [vrsp_pkg::STEP_W-1:0] pc_r, pc_nxt;
  logic [vrsp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  vrsp_pkg::cw_t               cw;
  logic                        fire;

  assign cw = vrsp_pkg::rom(pc_r);
  assign in_ready = (cw.cond == vrsp_pkg::COND_IN_WAIT);
  assign ctrl = fire ? cw.op : '0;

  always_comb begin
    pc_nxt = pc_r;
    cnt_nxt = cnt_r;
    fire = 1'b1;
    case (cw.cond)
      vrsp_pkg::COND_NEXT: begin
        pc_nxt = pc_r + vrsp_pkg::STEP_W'(1);
      end
      vrsp_pkg::COND_GOTO: begin
        pc_nxt = cw.target;
      end
      vrsp_pkg::COND_IN_WAIT: begin
        fire = in_valid;
        if (in_valid) begin
          pc_nxt = in_command ? pc_r + vrsp_pkg::STEP_W'(1) : cw.target;
        end
      end
      vrsp_pkg::COND_LOOP: begin
        if (cnt_r != '0) begin
          pc_nxt = cw.target;
          cnt_nxt = cnt_r - vrsp_pkg::CNT_W'(1);
        end else begin
          pc_nxt = pc_r + vrsp_pkg::STEP_W'(1);
        end
      end
      vrsp_pkg::COND_OUT_WAIT: begin
        fire = !out_busy;
        if (!out_busy) begin
          pc_nxt = cw.target;
        end
      end
      default: begin
        pc_nxt = vrsp_pkg::STEP_IDLE;
      end
    endcase
    if (fire && cw.op.sq_init) begin
      cnt_nxt = vrsp_pkg::CNT_W'(vrsp_pkg::ROOT_W - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= vrsp_pkg::STEP_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `VRSP_ASSERT_NXT(a_accept_dispatch, in_valid && in_ready, (pc_r == vrsp_pkg::STEP_MUL) || (pc_r == vrsp_pkg::STEP_RAMP), "accepted word did not dispatch")
  `VRSP_ASSERT_NXT(a_root_loop_holds, (pc_r == vrsp_pkg::STEP_SQ) && (cnt_r != '0), pc_r == vrsp_pkg::STEP_SQ, "root loop left early")
  `VRSP_ASSERT_NXT(a_root_count_load, pc_r == vrsp_pkg::STEP_SQINIT, (pc_r == vrsp_pkg::STEP_SQ) && (cnt_r == vrsp_pkg::CNT_W'(vrsp_pkg::ROOT_W - 1)), "root count not loaded")

endmodule

### src/vrsp_dp.sv
// datapath: config registers, multiplier, bit-pair root, goal clamp, ramp and output register
// depends on vrsp_pkg, driven by the control word of vrsp_seq
module vrsp_dp #(
  parameter int FRACTION_BITS = 10,
  parameter int ACCEL_SHIFT   = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vrsp_pkg::ctrl_t                     ctrl,
  input  logic                                cfg_we,
  input  logic [vrsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrsp_pkg::ACCEL_W-1:0]        cfg_data,
  input  logic signed [vrsp_pkg::DIST_W-1:0]  in_remaining_distance,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [vrsp_pkg::SPEED_W-1:0] out_speed_out,
  output logic                                out_busy
);

  localparam int VEL_W = vrsp_pkg::SPEED_W + FRACTION_BITS;
  localparam int ACC_W = vrsp_pkg::ACCEL_W + ACCEL_SHIFT;
  localparam int SUM_W = VEL_W + ACC_W + 1;
  localparam int CV_W  = vrsp_pkg::ROOT_W + 2;

  logic signed [vrsp_pkg::SPEED_W-1:0] target_r;
  logic [vrsp_pkg::ACCEL_W-1:0]        accel_r;
  logic signed [vrsp_pkg::DIST_W-1:0]  dist_r;
  logic [vrsp_pkg::PROD_W-1:0]         prod_r;
  logic [vrsp_pkg::PROD_W-1:0]         x_r, r_r, bit_r;
  logic signed [vrsp_pkg::SPEED_W-1:0] goal_r;
  logic signed [VEL_W-1:0]             vel_r;
  logic                                out_valid_r;
  logic signed [vrsp_pkg::SPEED_W-1:0] out_speed_r;

  logic [vrsp_pkg::DIST_W-1:0]         mag;
  logic [vrsp_pkg::PROD_W-1:0]         try_sum;
  logic signed [CV_W-1:0]              cv, tx;
  logic signed [vrsp_pkg::SPEED_W-1:0] goal_clamped;
  logic signed [SUM_W-1:0]             g_s, v_s, a_s, t_s, vn_s;

  assign out_valid = out_valid_r;
  assign out_speed_out = out_speed_r;
  assign out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      accel_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vrsp_pkg::REG_TARGET_SPEED:   target_r <= cfg_data;
        vrsp_pkg::REG_ACCEL_PER_TICK: accel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitude of the distance, full 2^24 case fits unsigned
  assign mag = dist_r[vrsp_pkg::DIST_W-1] ? vrsp_pkg::DIST_W'(-dist_r)
                                          : vrsp_pkg::DIST_W'(dist_r);

  assign try_sum = r_r + bit_r;

  // signed root, clamp on target side, saturate on the other
  always_comb begin
    cv = CV_W'(r_r[vrsp_pkg::ROOT_W-1:0]);
    if (dist_r[vrsp_pkg::DIST_W-1]) begin
      cv = -cv;
    end
    tx = CV_W'(target_r);
    if (!target_r[vrsp_pkg::SPEED_W-1]) begin
      if (cv > tx) cv = tx;
    end else begin
      if (cv < tx) cv = tx;
    end
    if (cv > CV_W'(32'sd32767)) cv = CV_W'(32'sd32767);
    if (cv < -CV_W'(32'sd32768)) cv = -CV_W'(32'sd32768);
    goal_clamped = cv[vrsp_pkg::SPEED_W-1:0];
  end

  // ramp toward goal, stop on it
  always_comb begin
    g_s = SUM_W'(goal_r) <<< FRACTION_BITS;
    v_s = SUM_W'(vel_r);
    a_s = $signed(SUM_W'(accel_r)) <<< ACCEL_SHIFT;
    vn_s = v_s;
    t_s = v_s;
    if (v_s < g_s) begin
      t_s = v_s + a_s;
      vn_s = (t_s > g_s) ? g_s : t_s;
    end else if (v_s > g_s) begin
      t_s = v_s - a_s;
      vn_s = (t_s < g_s) ? g_s : t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      dist_r <= in_remaining_distance;
      goal_r <= target_r;
    end
    if (ctrl.mul_en) begin
      prod_r <= vrsp_pkg::PROD_W'({accel_r, 1'b0}) * vrsp_pkg::PROD_W'(mag);
    end
    if (ctrl.sq_init) begin
      x_r <= prod_r;
      r_r <= '0;
      bit_r <= vrsp_pkg::PROD_W'(1) << (vrsp_pkg::PROD_W - 2);
    end else if (ctrl.sq_step) begin
      if (x_r >= try_sum) begin
        x_r <= x_r - try_sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (ctrl.clamp_en) begin
      goal_r <= goal_clamped;
    end
    if (ctrl.ramp_en) begin
      out_speed_r <= vn_s[VEL_W-1:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.ramp_en) begin
        vel_r <= vn_s[VEL_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### src/velocity_ramp_with_stop_profile_unit.sv
// top level of the velocity ramp unit with stop-to-position profile
// depends on vrsp_pkg, vrsp_seq and vrsp_dp
//
// Each accepted word is one control tick. The unit keeps a signed fixed-point
// velocity (FRACTION_BITS fraction bits) and moves it toward a goal by at most
// accel_per_tick << ACCEL_SHIFT per tick, stopping exactly on the goal; one
// result word carries the integer part (arithmetic shift, rounds toward minus
// infinity). A plain tick (command 0) goes from acceptance straight to the
// ramp toward target_speed. A stop tick (command 1) first forms
// sign(d) * floor(sqrt(2 * accel_per_tick * |d|)), clamps it so it never
// passes target_speed on target_speed's side and saturates it to 16 bits on
// the other, then ramps; it forms the root by the 21-step bit-pair
// square root that the sequencer runs on one shared add/compare unit. The
// next word is accepted once the previous tick has reached the output
// register, so a result waiting on out_ready only delays a second one.
// Configuration writes are taken at once and belong to idle periods.
module velocity_ramp_with_stop_profile_unit #(
  parameter int FRACTION_BITS = 10,
  parameter int ACCEL_SHIFT   = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [vrsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrsp_pkg::ACCEL_W-1:0]        cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [vrsp_pkg::DIST_W-1:0]  in_remaining_distance,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vrsp_pkg::SPEED_W-1:0] out_speed_out
);

  vrsp_pkg::ctrl_t ctrl;   // gated control word for this cycle
  logic            out_busy;

  // step counter, loop counter and control rom
  vrsp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_busy   (out_busy),
    .in_ready   (in_ready),
    .ctrl       (ctrl)
  );

  // arithmetic, state and output register
  vrsp_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .ACCEL_SHIFT   (ACCEL_SHIFT)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_remaining_distance (in_remaining_distance),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_speed_out         (out_speed_out),
    .out_busy              (out_busy)
  );

endmodule

### tb/tb_velocity_ramp_with_stop_profile_unit.sv
// self-checking testbench for velocity_ramp_with_stop_profile_unit: speed scoreboard class
// and top module with stimulus tasks; depends on vrsp_pkg and the unit's rtl only
`timescale 1ns / 1ps

// keeps its own copy of the registers and the fixed-point velocity and holds
// the speed words the unit owes, oldest first
class ramp_speed_checker;
  localparam int FRAC_BITS   = 10;
  localparam int ACCEL_SHIFT = 0;

  logic signed [vrsp_pkg::SPEED_W-1:0] target_speed;
  logic [vrsp_pkg::ACCEL_W-1:0]        accel_step;
  longint                              velocity;
  logic signed [vrsp_pkg::SPEED_W-1:0] expected_speeds[$];
  int                                  mismatches;
  int                                  words_checked;

  function new();
    target_speed  = '0;
    accel_step    = '0;
    velocity      = 0;
    mismatches    = 0;
    words_checked = 0;
  endfunction

  function void write_reg(logic [vrsp_pkg::CFG_IDX_W-1:0] idx,
                          logic [vrsp_pkg::ACCEL_W-1:0] data);
    if (idx == vrsp_pkg::REG_TARGET_SPEED)
      target_speed = data;
    else if (idx == vrsp_pkg::REG_ACCEL_PER_TICK)
      accel_step = data;
  endfunction

  // bit-pair square root, rounds down
  static function longint unsigned floor_root(longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = x;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem)
      bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function void note_tick(logic stop_tick, logic signed [vrsp_pkg::DIST_W-1:0] distance);
    longint          goal;
    longint          dist_l;
    longint          root;
    longint          goal_fx;
    longint          accel_fx;
    longint unsigned mag;
    goal = target_speed;
    if (stop_tick) begin
      dist_l = distance;
      mag    = (dist_l < 0) ? -dist_l : dist_l;
      root   = floor_root(64'(accel_step) * 2 * mag);
      goal   = (dist_l > 0) ? root : -root;
      // clamp on the target's side only, saturate on the other
      if (target_speed >= 0) begin
        if (goal > target_speed) goal = target_speed;
      end else begin
        if (goal < target_speed) goal = target_speed;
      end
      if (goal > 32767)  goal = 32767;
      if (goal < -32768) goal = -32768;
    end
    goal_fx  = goal * (longint'(1) << FRAC_BITS);
    accel_fx = longint'(accel_step) << ACCEL_SHIFT;
    if (velocity < goal_fx) begin
      velocity = velocity + accel_fx;
      if (velocity > goal_fx) velocity = goal_fx;
    end else if (velocity > goal_fx) begin
      velocity = velocity - accel_fx;
      if (velocity < goal_fx) velocity = goal_fx;
    end
    expected_speeds.push_back(16'(velocity >>> FRAC_BITS));
  endfunction

  function void check_speed(logic signed [vrsp_pkg::SPEED_W-1:0] got);
    logic signed [vrsp_pkg::SPEED_W-1:0] want;
    words_checked++;
    if (expected_speeds.size() == 0) begin
      $display("%0t ns: speed_out mismatch, expected none, got %0d", $time, got);
      mismatches++;
    end else begin
      want = expected_speeds.pop_front();
      if (got !== want) begin
        $display("%0t ns: speed_out mismatch, expected %0d, got %0d", $time, want, got);
        mismatches++;
      end
    end
  endfunction
endclass

module tb_velocity_ramp_with_stop_profile_unit;

  localparam int CLK_PERIOD_NS   = 20;
  localparam int RESET_CYCLES    = 9;
  // longer than a stop tick takes, so this covers anything still in flight
  localparam int SETTLE_CYCLES   = 40;
  localparam int STALL_LIMIT     = 3000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int IDLE_PCT        = 37;
  localparam int FRAC_BITS       = 10;

  localparam logic CMD_RAMP = 1'b0;
  localparam logic CMD_STOP = 1'b1;

  localparam logic signed [vrsp_pkg::DIST_W-1:0] DIST_MAX =
    {1'b0, {(vrsp_pkg::DIST_W-1){1'b1}}};
  localparam logic signed [vrsp_pkg::DIST_W-1:0] DIST_MIN =
    {1'b1, {(vrsp_pkg::DIST_W-1){1'b0}}};

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [vrsp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [vrsp_pkg::ACCEL_W-1:0]        cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_command = 1'b0;
  logic signed [vrsp_pkg::DIST_W-1:0]  in_remaining_distance = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [vrsp_pkg::SPEED_W-1:0] out_speed_out;

  // chance in a hundred that a side idles in a given cycle
  int idle_pct = IDLE_PCT;
  int ticks_sent = 0;
  int stop_ticks = 0;
  int profiles_loaded = 0;
  int stall_cycles = 0;

  ramp_speed_checker speed_sb = new();

  velocity_ramp_with_stop_profile_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_remaining_distance (in_remaining_distance),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_speed_out         (out_speed_out)
  );

  initial begin
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  // result side: every word taken is checked against the oldest expectation,
  // then ready is redrawn for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      speed_sb.check_speed(out_speed_out);
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // watchdog: counts cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t ns: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offers one tick, with random idle cycles in front, and returns in the
  // time step of the edge that takes it; valid is left high on purpose
  task automatic send_tick(input logic cmd,
                           input logic signed [vrsp_pkg::DIST_W-1:0] distance);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_command            <= cmd;
    in_remaining_distance <= distance;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    speed_sb.note_tick(cmd, distance);
    ticks_sent++;
    if (cmd == CMD_STOP)
      stop_ticks++;
  endtask

  // stop sending and wait for every owed speed word, then let the unit settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (speed_sb.expected_speeds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back; only called with the unit idle
  task automatic set_profile(input logic signed [vrsp_pkg::SPEED_W-1:0] target,
                             input logic [vrsp_pkg::ACCEL_W-1:0] accel);
    cfg_we    <= 1'b1;
    cfg_index <= vrsp_pkg::REG_TARGET_SPEED;
    cfg_data  <= target;
    @(posedge clk);
    speed_sb.write_reg(vrsp_pkg::REG_TARGET_SPEED, target);
    cfg_index <= vrsp_pkg::REG_ACCEL_PER_TICK;
    cfg_data  <= accel;
    @(posedge clk);
    speed_sb.write_reg(vrsp_pkg::REG_ACCEL_PER_TICK, accel);
    cfg_we <= 1'b0;
    profiles_loaded++;
  endtask

  function automatic logic signed [vrsp_pkg::DIST_W-1:0] random_distance();
    case ($urandom_range(3))
      0:       return 25'(int'($urandom_range(4000)) - 2000);
      1:       return 25'($urandom());
      2:       return 25'(int'($urandom_range(2_000_000)) - 1_000_000);
      default: return $urandom_range(1) ? DIST_MAX : DIST_MIN;
    endcase
  endfunction

  // small targets dominate so that the velocity actually reaches them
  function automatic logic signed [vrsp_pkg::SPEED_W-1:0] random_target();
    case ($urandom_range(4))
      0:       return 16'($urandom());
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      default: return 16'(int'($urandom_range(800)) - 400);
    endcase
  endfunction

  function automatic logic [vrsp_pkg::ACCEL_W-1:0] random_accel();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(3000, 1));
    endcase
  endfunction

  // a run-up of plain ticks, then stop ticks whose distance shrinks by the
  // current speed each tick, the way a real approach to a stop point does
  task automatic run_approach();
    longint dist_left;
    longint speed_now;
    int     budget;
    repeat ($urandom_range(12)) send_tick(CMD_RAMP, random_distance());
    dist_left = $urandom_range(1) ? $urandom_range(500) : $urandom_range(1_000_000);
    // mostly head towards the target's side, now and then against it
    if ((speed_sb.target_speed < 0) != ($urandom_range(9) == 0))
      dist_left = -dist_left;
    budget = $urandom_range(40, 10);
    repeat (budget) begin
      send_tick(CMD_STOP, 25'(dist_left));
      speed_now = speed_sb.velocity >>> FRAC_BITS;
      dist_left = dist_left - speed_now;
      if (dist_left > longint'(DIST_MAX)) dist_left = DIST_MAX;
      if (dist_left < longint'(DIST_MIN)) dist_left = DIST_MIN;
    end
  endtask

  initial begin
    int phase_goal;
    int pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // fastest climb to the top of the range, zero distance, both distance extremes
    set_profile(16'sh7FFF, 16'hFFFF);
    send_tick(CMD_RAMP, '0);
    send_tick(CMD_RAMP, DIST_MAX);
    send_tick(CMD_STOP, '0);
    send_tick(CMD_STOP, DIST_MAX);
    send_tick(CMD_STOP, DIST_MIN);
    send_tick(CMD_RAMP, DIST_MIN);
    drain_results();

    // zero acceleration: the velocity must hold whatever the goal
    set_profile(16'sh8000, '0);
    send_tick(CMD_RAMP, '0);
    send_tick(CMD_STOP, 25'sd12345);
    send_tick(CMD_STOP, -25'sd12345);
    drain_results();

    // stop goal on the far side of a negative target saturates at the top
    set_profile(16'sh8000, 16'hFFFF);
    send_tick(CMD_STOP, DIST_MAX);
    send_tick(CMD_RAMP, '0);
    send_tick(CMD_RAMP, '0);
    send_tick(CMD_STOP, DIST_MIN);
    drain_results();

    // ... and at the bottom for a positive target; then short distances
    set_profile(16'sd100, 16'd1000);
    send_tick(CMD_STOP, DIST_MIN);
    send_tick(CMD_STOP, 25'sd5);
    send_tick(CMD_STOP, -25'sd5);
    send_tick(CMD_STOP, '0);
    send_tick(CMD_RAMP, '0);
    send_tick(CMD_RAMP, '0);
    drain_results();

    // random phases, each with its own profile; one phase runs with no idling
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase == 4) ? 0 : IDLE_PCT;
      set_profile(random_target(), random_accel());
      phase_goal = ticks_sent + ITEMS_PER_PHASE;
      while (ticks_sent < phase_goal) begin
        pick = $urandom_range(29);
        if (pick < 17)
          run_approach();
        else if (pick == 17)
          drain_results();
        else
          send_tick(1'($urandom()), random_distance());
      end
      drain_results();
    end

    $display("%0d ticks sent (%0d stop ticks) under %0d register settings",
             ticks_sent, stop_ticks, profiles_loaded);
    $display("%0d speed words checked, %0d mismatches",
             speed_sb.words_checked, speed_sb.mismatches);
    if (speed_sb.mismatches == 0 && speed_sb.expected_speeds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
